>>> rtl/core/sorted_insert_priority_queue_core_assert.svh
// assertion macros used by the queue datapath
`ifndef SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SIPQ_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sipq invariant violated");

// consequent holds in the same cycle as the antecedent
`define SIPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sipq implication violated");

// consequent holds in the cycle after the antecedent
`define SIPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sipq next-cycle check violated");

`endif

>>> rtl/core/sipq_pkg.sv
`default_nettype none

package sipq_pkg;

    localparam int unsigned DEPTH_DEF     = 16;
    localparam int unsigned PRIO_BITS_DEF = 8;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned PRIO_PORT_W = 8;
    localparam int unsigned FILL_W      = 5;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic rd_prev;
        logic rd_head;
        logic shift;
        logic insert;
        logic pop;
        logic rej_full;
        logic rej_empty;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_deq;
        logic is_enq;
        logic full;
        logic empty;
        logic k_zero;
        logic greater;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/sipq_ctrl.sv
`default_nettype none

module sipq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sipq_pkg::t_stat i_stat,
    output sipq_pkg::t_cmd  o_cmd
);
    import sipq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_CMP    = 2'd2;
    localparam logic [1:0] S_POP    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_deq) begin
                    if (i_stat.empty) begin
                        if (i_stat.out_free) begin
                            o_cmd.rej_empty = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end else begin
                        o_cmd.rd_head = 1'b1;
                        n_state       = S_POP;
                    end
                end else if (i_stat.full) begin
                    if (i_stat.out_free) begin
                        o_cmd.rej_full = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.k_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.insert = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                // move the larger entry up one slot, else drop the new one here
                if (i_stat.greater) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_DECIDE;
                end else if (i_stat.out_free) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sipq_dpath.sv
`default_nettype none

module sipq_dpath #(
    parameter int unsigned DEPTH     = sipq_pkg::DEPTH_DEF,
    parameter int unsigned PRIO_BITS = sipq_pkg::PRIO_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_op,
    input  logic [sipq_pkg::DATA_W-1:0]         i_data,
    input  logic [sipq_pkg::PRIO_PORT_W-1:0]    i_prio,
    input  sipq_pkg::t_cmd                      i_cmd,
    output sipq_pkg::t_stat                     o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [sipq_pkg::STATUS_W-1:0]       o_status,
    output logic [sipq_pkg::DATA_W-1:0]         o_data,
    output logic [sipq_pkg::PRIO_PORT_W-1:0]    o_prio,
    output logic [sipq_pkg::FILL_W-1:0]         o_fill
);
    `include "sorted_insert_priority_queue_core_assert.svh"
    import sipq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]    mem_data [DEPTH];
    logic [PRIO_BITS-1:0] mem_prio [DEPTH];

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_k;
    logic                 r_op;
    logic [DATA_W-1:0]    r_din;
    logic [PRIO_BITS-1:0] r_pin;
    logic [DATA_W-1:0]    r_rd_data;
    logic [PRIO_BITS-1:0] r_rd_prio;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [DATA_W-1:0]      r_out_data;
    logic [PRIO_PORT_W-1:0] r_out_prio;
    logic [FILL_W-1:0]      r_out_fill;

    logic [PRIO_BITS+PRIO_PORT_W-1:0] pin_wide;
    logic [PRIO_BITS+PRIO_PORT_W-1:0] pout_wide;
    logic [CW+FILL_W-1:0]             fill_wide;
    logic [CW-1:0]                    km1;
    logic [AW-1:0]                    rd_l;
    logic [AW:0]                      rd_sum;
    logic [AW:0]                      wr_sum;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic                             we;
    logic                             re;
    logic                             load;
    logic [DATA_W-1:0]                wdata;
    logic [PRIO_BITS-1:0]             wprio;
    logic [STATUS_W-1:0]              res_status;

    // priority kept in its low PRIO_BITS bits, read back through the 8-bit field
    assign pin_wide  = {{PRIO_BITS{1'b0}}, i_prio};
    assign pout_wide = {{PRIO_PORT_W{1'b0}}, r_rd_prio};
    assign fill_wide = {{FILL_W{1'b0}}, n_count};

    // logical slot to ring address, head + slot stays below twice the depth
    assign km1    = r_k - CW'(1);
    assign rd_l   = i_cmd.rd_head ? '0 : km1[AW-1:0];
    assign rd_sum = {1'b0, r_head} + {1'b0, rd_l};
    assign wr_sum = {1'b0, r_head} + {1'b0, r_k[AW-1:0]};

    always_comb begin
        rd_addr = rd_sum[AW-1:0];
        if (rd_sum >= (AW + 1)'(DEPTH)) begin
            rd_addr = AW'(rd_sum - (AW + 1)'(DEPTH));
        end
        wr_addr = wr_sum[AW-1:0];
        if (wr_sum >= (AW + 1)'(DEPTH)) begin
            wr_addr = AW'(wr_sum - (AW + 1)'(DEPTH));
        end
    end

    assign we    = i_cmd.shift | i_cmd.insert;
    assign re    = i_cmd.rd_prev | i_cmd.rd_head;
    assign wdata = i_cmd.shift ? r_rd_data : r_din;
    assign wprio = i_cmd.shift ? r_rd_prio : r_pin;
    assign load  = i_cmd.insert | i_cmd.pop | i_cmd.rej_full | i_cmd.rej_empty;

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        priority if (i_cmd.rej_full) begin
            res_status = ST_FULL;
        end else if (i_cmd.rej_empty) begin
            res_status = ST_EMPTY;
        end else begin
            res_status = ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_data[wr_addr] <= wdata;
            mem_prio[wr_addr] <= wprio;
        end
        if (re) begin
            r_rd_data <= mem_data[rd_addr];
            r_rd_prio <= mem_prio[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_op;
            r_din <= i_data;
            r_pin <= pin_wide[PRIO_BITS-1:0];
        end
        if (i_cmd.latch) begin
            r_k <= r_count;
        end else if (i_cmd.shift) begin
            r_k <= km1;
        end
        if (load) begin
            r_out_status <= res_status;
            r_out_data   <= i_cmd.pop ? r_rd_data : '0;
            r_out_prio   <= i_cmd.pop ? pout_wide[PRIO_PORT_W-1:0] : '0;
            r_out_fill   <= fill_wide[FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.pop) begin
                r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_deq   = (r_op == OP_DEQ);
    assign o_stat.is_enq   = (r_op == OP_ENQ);
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.k_zero   = (r_k == '0);
    assign o_stat.greater  = (r_rd_prio > r_pin);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data      = r_out_data;
    assign o_prio      = r_out_prio;
    assign o_fill      = r_out_fill;

    `SIPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `SIPQ_ASSERT_IMP(a_insert_not_full, i_clk, i_rst_n, i_cmd.insert, r_count != CW'(DEPTH))
    `SIPQ_ASSERT_IMP(a_result_slot_free, i_clk, i_rst_n, load, !r_out_valid || i_out_ready)
    `SIPQ_ASSERT_IMP(a_shift_only_enq, i_clk, i_rst_n, i_cmd.shift, o_stat.is_enq && r_k != '0)
    `SIPQ_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, i_cmd.pop, r_count == $past(r_count) - CW'(1))

endmodule

`default_nettype wire

>>> rtl/core/sorted_insert_priority_queue_core.sv
// Sorted-insert priority queue holding up to DEPTH entries, each a data byte and a
// priority, leaving in ascending priority order and in arrival order among equal
// priorities. The entries sit in a ring memory with a head pointer and a count,
// sorted from the head. One transaction at a time is worked on: a dequeue is
// accepted, reads the head entry and pops it; a rejected enqueue or a dequeue on
// an empty queue is accepted and then answered; an enqueue is accepted, then each
// stored entry with a larger priority number moves up one slot through a read and
// then a write on the memory, starting from the tail, and the new entry goes into
// the freed slot. The result sits in an output register, so the next transaction
// is accepted while it waits to be taken; a result waits for that register to
// drain before it is written. No clearing pass is made after reset.
`default_nettype none

module sorted_insert_priority_queue_core #(
    parameter int unsigned DEPTH     = sipq_pkg::DEPTH_DEF,     // 2 to 31 entries
    parameter int unsigned PRIO_BITS = sipq_pkg::PRIO_BITS_DEF  // stored priority bits
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input transaction
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sipq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // data_in[7:0], prio_in[15:8]
    input  logic [0:0]                         s_axis_tuser,   // op[0]
    // result transaction
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sipq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // data_out[7:0], prio_out[15:8],
                                                               // fill[20:16], zero[23:21]
    output logic [sipq_pkg::STATUS_W-1:0]      m_axis_tuser    // status[1:0]
);
    import sipq_pkg::*;

    t_cmd cmd;
    t_stat stat;

    logic [DATA_W-1:0]      out_data;
    logic [PRIO_PORT_W-1:0] out_prio;
    logic [FILL_W-1:0]      out_fill;

    // sequencer: decides each step of insert or pop from datapath status
    sipq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // ring memory, count, head, compare and result register
    sipq_dpath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tuser[0]),
        .i_data      (s_axis_tdata[DATA_W-1:0]),
        .i_prio      (s_axis_tdata[IN_TDATA_W-1:DATA_W]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_data      (out_data),
        .o_prio      (out_prio),
        .o_fill      (out_fill)
    );

    // pack result fields, lowest field first, padded to whole bytes
    assign m_axis_tdata = {{(OUT_TDATA_W - DATA_W - PRIO_PORT_W - FILL_W){1'b0}},
                           out_fill, out_prio, out_data};

endmodule

`default_nettype wire
